// ===== rtl/vsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared types and codes for the synthesizer voice allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

    // Result action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_RETRIG  = 3'd2;
    localparam logic [2:0] ACT_STEAL   = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;
    localparam logic [2:0] ACT_ENDED   = 3'd6;

    // Decoded request operations
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ON   = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;
    localparam logic [1:0] OP_END  = 2'd3;

    // MIDI status kinds (high nibble)
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

    localparam int FRAME_W = 48;

    // Decoded request
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] note;
        logic [3:0] ch4;
        logic [4:0] chan;
        logic       has_rel;
        logic [3:0] slot;
    } evt_t;

    // Voice table entry kept in the tag RAM
    typedef struct packed {
        logic       rel;
        logic [6:0] note;
        logic [3:0] ch4;
    } entry_t;

endpackage

// ===== rtl/synth_voice_allocator_top.sv =====
// ----------------------------------------------------------------------------
// synth_voice_allocator_top
// Polyphonic voice allocator with oldest-voice stealing.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. A request ignored by decode
// or a voice-end notice for a voice that is not active goes straight to the
// finish state, a voice-end notice for an active voice reads its table entry
// and writes it back first, and a note-on or note-off scans all voices and
// then decides: the voice table lives in two RAMs with one read port, and the
// note scan reads one voice per cycle to find a retrigger match, the lowest
// free voice and the oldest voice together. Active marks are flops cleared by
// reset. A finished result sits in an output register, so the next request is
// taken while the previous result still waits on out_stall.
module synth_voice_allocator_top #(
    parameter int NUM_VOICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  status_byte,
    input  logic [6:0]  note_number,
    input  logic [6:0]  velocity,
    input  logic [1:0]  byte_count,
    input  logic        zone_playable,
    input  logic        zone_has_release,
    input  logic [47:0] frame_time,
    input  logic [3:0]  voice_slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  voice_index,
    output logic [2:0]  action,
    output logic [4:0]  voice_channel
);

    localparam int IDX_W = $clog2(NUM_VOICES);
    localparam int ENT_W = $bits(vsa_pkg::entry_t);
    localparam int FW    = vsa_pkg::FRAME_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_END_RD = 3'd3;
    localparam logic [2:0] ST_END_WB = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    localparam logic [IDX_W:0]   CNT_END  = (IDX_W+1)'(NUM_VOICES);
    localparam logic [IDX_W:0]   CNT_ONE  = (IDX_W+1)'(1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_VOICES - 1);

    // control state
    logic [2:0]            state_reg, state_next;
    logic [4:0]            listen_reg, listen_next;
    logic [NUM_VOICES-1:0] active_reg, active_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  match_found_reg, match_found_next;
    logic                  free_found_reg, free_found_next;
    logic                  best_valid_reg, best_valid_next;

    // payload state
    logic                  is_on_reg, is_on_next;
    logic [6:0]            note_reg, note_next;
    logic [3:0]            ch4_reg, ch4_next;
    logic [4:0]            chan_reg, chan_next;
    logic                  has_rel_reg, has_rel_next;
    logic [FW-1:0]         frame_reg, frame_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [IDX_W:0]        issue_cnt_reg, issue_cnt_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]      match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [FW-1:0]         best_start_reg, best_start_next;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    logic [2:0]            res_act_reg, res_act_next;
    logic [4:0]            res_chan_reg, res_chan_next;
    logic [3:0]            out_idx_reg, out_idx_next;
    logic [2:0]            out_act_reg, out_act_next;
    logic [4:0]            out_chan_reg, out_chan_next;

    // RAM ports
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [IDX_W-1:0]      ram_waddr;
    logic                  tag_we;
    vsa_pkg::entry_t       tag_wdata;
    logic [ENT_W-1:0]      tag_rdata;
    logic                  start_we;
    logic [FW-1:0]         start_rdata;

    vsa_pkg::evt_t         evt;
    vsa_pkg::entry_t       rd_entry;
    logic [IDX_W-1:0]      evt_slot;
    logic                  slot_ok;
    logic                  rd_active;
    logic [IDX_W-1:0]      pick_idx;

    vsa_decode u_decode (
        .mode             (mode),
        .status_byte      (status_byte),
        .note_number      (note_number),
        .velocity         (velocity),
        .byte_count       (byte_count),
        .zone_playable    (zone_playable),
        .zone_has_release (zone_has_release),
        .voice_slot       (voice_slot),
        .listen_channel   (listen_reg),
        .evt              (evt)
    );

    // note, channel and release mark per voice
    vsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_VOICES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (ram_waddr),
        .wdata (tag_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (tag_rdata)
    );

    // start frame per voice
    vsa_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_VOICES)
    ) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (ram_waddr),
        .wdata (frame_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (start_rdata)
    );

    assign rd_entry  = tag_rdata;
    assign evt_slot  = IDX_W'(evt.slot);
    assign slot_ok   = int'(evt.slot) < NUM_VOICES;
    assign rd_active = active_reg[rd_idx_reg];
    assign pick_idx  = match_found_reg ? match_idx_reg :
                       free_found_reg  ? free_idx_reg  : best_idx_reg;

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign voice_index   = out_idx_reg;
    assign action        = out_act_reg;
    assign voice_channel = out_chan_reg;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        listen_next      = cfg_we ? cfg_wdata : listen_reg;
        active_next      = active_reg;
        out_valid_next   = out_valid_reg && out_stall;
        rd_valid_next    = 1'b0;
        match_found_next = match_found_reg;
        free_found_next  = free_found_reg;
        best_valid_next  = best_valid_reg;
        is_on_next       = is_on_reg;
        note_next        = note_reg;
        ch4_next         = ch4_reg;
        chan_next        = chan_reg;
        has_rel_next     = has_rel_reg;
        frame_next       = frame_reg;
        slot_next        = slot_reg;
        issue_cnt_next   = issue_cnt_reg;
        rd_idx_next      = rd_idx_reg;
        match_idx_next   = match_idx_reg;
        free_idx_next    = free_idx_reg;
        best_idx_next    = best_idx_reg;
        best_start_next  = best_start_reg;
        res_idx_next     = res_idx_reg;
        res_act_next     = res_act_reg;
        res_chan_next    = res_chan_reg;
        out_idx_next     = out_idx_reg;
        out_act_next     = out_act_reg;
        out_chan_next    = out_chan_reg;
        ram_re           = 1'b0;
        ram_raddr        = slot_reg;
        ram_waddr        = pick_idx;
        tag_we           = 1'b0;
        tag_wdata        = '{rel: 1'b0, note: note_reg, ch4: ch4_reg};
        start_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    note_next        = evt.note;
                    ch4_next         = evt.ch4;
                    chan_next        = evt.chan;
                    has_rel_next     = evt.has_rel;
                    frame_next       = frame_time;
                    slot_next        = evt_slot;
                    is_on_next       = (evt.op == vsa_pkg::OP_ON);
                    issue_cnt_next   = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    best_valid_next  = 1'b0;
                    res_idx_next     = '0;
                    res_act_next     = vsa_pkg::ACT_NONE;
                    res_chan_next    = 5'd0;
                    unique case (evt.op)
                        vsa_pkg::OP_END:
                        begin
                            if (slot_ok && active_reg[evt_slot])
                            begin
                                state_next = ST_END_RD;
                            end
                            else
                            begin
                                state_next = ST_FIN;
                            end
                        end
                        vsa_pkg::OP_ON, vsa_pkg::OP_OFF:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle
                if (issue_cnt_reg != CNT_END)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = issue_cnt_reg[IDX_W-1:0];
                    rd_valid_next  = 1'b1;
                    rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + CNT_ONE;
                end
                // evaluate the entry read last cycle
                if (rd_valid_reg)
                begin
                    if (rd_active && !match_found_reg && rd_entry.note == note_reg
                        && rd_entry.ch4 == ch4_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = rd_idx_reg;
                    end
                    if (!rd_active && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if (rd_active && (!best_valid_reg || start_rdata < best_start_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_start_next = start_rdata;
                    end
                    if (rd_idx_reg == IDX_LAST)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_FIN;
                if (is_on_reg)
                begin
                    tag_we                = 1'b1;
                    start_we              = 1'b1;
                    active_next[pick_idx] = 1'b1;
                    res_idx_next          = pick_idx;
                    res_chan_next         = chan_reg;
                    res_act_next          = match_found_reg ? vsa_pkg::ACT_RETRIG :
                                            free_found_reg  ? vsa_pkg::ACT_START  :
                                                              vsa_pkg::ACT_STEAL;
                end
                else if (match_found_reg)
                begin
                    tag_we        = 1'b1;
                    ram_waddr     = match_idx_reg;
                    res_idx_next  = match_idx_reg;
                    res_chan_next = chan_reg;
                    if (has_rel_reg)
                    begin
                        tag_wdata.rel = 1'b1;
                        res_act_next  = vsa_pkg::ACT_RELEASE;
                    end
                    else
                    begin
                        active_next[match_idx_reg] = 1'b0;
                        res_act_next               = vsa_pkg::ACT_STOP;
                    end
                end
            end

            ST_END_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = slot_reg;
                state_next = ST_END_WB;
            end

            ST_END_WB:
            begin
                // clear the release mark, keep note and channel
                tag_we                = 1'b1;
                ram_waddr             = slot_reg;
                tag_wdata             = '{rel: 1'b0, note: rd_entry.note, ch4: rd_entry.ch4};
                active_next[slot_reg] = 1'b0;
                res_idx_next          = slot_reg;
                res_act_next          = vsa_pkg::ACT_ENDED;
                res_chan_next         = {1'b0, rd_entry.ch4} + 5'd1;
                state_next            = ST_FIN;
            end

            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = 4'(res_idx_reg);
                    out_act_next   = res_act_reg;
                    out_chan_next  = res_chan_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            listen_reg      <= 5'd0;
            active_reg      <= '0;
            out_valid_reg   <= 1'b0;
            rd_valid_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            listen_reg      <= listen_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
            rd_valid_reg    <= rd_valid_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            best_valid_reg  <= best_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        is_on_reg      <= is_on_next;
        note_reg       <= note_next;
        ch4_reg        <= ch4_next;
        chan_reg       <= chan_next;
        has_rel_reg    <= has_rel_next;
        frame_reg      <= frame_next;
        slot_reg       <= slot_next;
        issue_cnt_reg  <= issue_cnt_next;
        rd_idx_reg     <= rd_idx_next;
        match_idx_reg  <= match_idx_next;
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        res_idx_reg    <= res_idx_next;
        res_act_reg    <= res_act_next;
        res_chan_reg   <= res_chan_next;
        out_idx_reg    <= out_idx_next;
        out_act_reg    <= out_act_next;
        out_chan_reg   <= out_chan_next;
    end

endmodule

// ===== rtl/vsa_ram.sv =====
// ----------------------------------------------------------------------------
// vsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/vsa_decode.sv =====
// ----------------------------------------------------------------------------
// vsa_decode
// Turns a raw request (MIDI bytes or voice-end notice) into an operation.
// ----------------------------------------------------------------------------
module vsa_decode (
    input  logic             mode,
    input  logic [7:0]       status_byte,
    input  logic [6:0]       note_number,
    input  logic [6:0]       velocity,
    input  logic [1:0]       byte_count,
    input  logic             zone_playable,
    input  logic             zone_has_release,
    input  logic [3:0]       voice_slot,
    input  logic [4:0]       listen_channel,
    output vsa_pkg::evt_t    evt
);

    logic [3:0] kind;
    logic [3:0] ch4;
    logic [4:0] chan;
    logic       vel_nz;
    logic       chan_ok;

    assign kind    = status_byte[7:4];
    assign ch4     = status_byte[3:0];
    assign chan    = {1'b0, ch4} + 5'd1;
    // two-byte events carry no velocity
    assign vel_nz  = (byte_count == 2'd3) && (velocity != 7'd0);
    assign chan_ok = (listen_channel == 5'd0) || (listen_channel == chan);

    always_comb
    begin
        evt.note    = note_number;
        evt.ch4     = ch4;
        evt.chan    = chan;
        evt.has_rel = zone_has_release;
        evt.slot    = voice_slot;
        evt.op      = vsa_pkg::OP_NONE;
        priority if (mode)
        begin
            evt.op = vsa_pkg::OP_END;
        end
        else if (byte_count < 2'd2 || !chan_ok)
        begin
            evt.op = vsa_pkg::OP_NONE;
        end
        else if (kind == vsa_pkg::KIND_NOTE_ON && vel_nz)
        begin
            evt.op = zone_playable ? vsa_pkg::OP_ON : vsa_pkg::OP_NONE;
        end
        else if (kind == vsa_pkg::KIND_NOTE_ON || kind == vsa_pkg::KIND_NOTE_OFF)
        begin
            evt.op = vsa_pkg::OP_OFF;
        end
        else
        begin
            // other status kinds are ignored
            evt.op = vsa_pkg::OP_NONE;
        end
    end

endmodule

// ===== rtl/vsa_checker.sv =====
// ----------------------------------------------------------------------------
// vsa_checker
// Port-level checks on the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vsa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] voice_index,
    input logic [2:0] action,
    input logic [4:0] voice_channel
);

    // no action reports voice 0 on channel 0
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == vsa_pkg::ACT_NONE |-> voice_index == 4'd0
        && voice_channel == 5'd0)
        else $error("no-action result carries voice or channel");

    // any real action names a channel 1..16
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != vsa_pkg::ACT_NONE |-> voice_channel != 5'd0
        && voice_channel <= 5'd16)
        else $error("action with channel out of range");

    // a request is worked on before the next one is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while previous one in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action)
        && $stable(voice_index) && $stable(voice_channel))
        else $error("stalled result changed");

endmodule

bind synth_voice_allocator_top vsa_checker u_vsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .voice_index   (voice_index),
    .action        (action),
    .voice_channel (voice_channel)
);

// ===== dv/tb_synth_voice_allocator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_synth_voice_allocator_top
// Self-checking bench for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
// A stimulus process fills a queue of MIDI and voice-end requests. A clocked
// driver presents them in bursts with random gaps. Each accepted request runs
// through a local voice-table model, and its result goes into a queue. A
// clocked monitor pops that queue and compares every accepted result field by
// field. The listen channel is changed between phases while the block is idle:
// all channels, both channel ends, one random inner channel, values matching none.
// ----------------------------------------------------------------------------
module tb_synth_voice_allocator_top;

    localparam int NUM_VOICES = 16;
    localparam int CYCLE_LIMIT = 500000;
    // Status kind that the allocator does not handle (poly pressure)
    localparam logic [3:0] KIND_POLY_PRESSURE = 4'hA;

    typedef struct packed {
        logic        mode;
        logic [7:0]  status;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [1:0]  count;
        logic        playable;
        logic        has_rel;
        logic [47:0] frame;
        logic [3:0]  slot;
    } midi_req_t;

    typedef struct packed {
        logic [3:0] idx;
        logic [2:0] act;
        logic [4:0] chan;
    } voice_result_t;

    // DUT ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = 1'b0;
    logic [7:0]  status_byte = '0;
    logic [6:0]  note_number = '0;
    logic [6:0]  velocity = '0;
    logic [1:0]  byte_count = '0;
    logic        zone_playable = 1'b0;
    logic        zone_has_release = 1'b0;
    logic [47:0] frame_time = '0;
    logic [3:0]  voice_slot = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  voice_index;
    logic [2:0]  action;
    logic [4:0]  voice_channel;

    synth_voice_allocator_top #(
        .NUM_VOICES (NUM_VOICES)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .status_byte      (status_byte),
        .note_number      (note_number),
        .velocity         (velocity),
        .byte_count       (byte_count),
        .zone_playable    (zone_playable),
        .zone_has_release (zone_has_release),
        .frame_time       (frame_time),
        .voice_slot       (voice_slot),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .voice_index      (voice_index),
        .action           (action),
        .voice_channel    (voice_channel)
    );

    // Local copy of the voice table and the listen channel
    logic        voice_on  [NUM_VOICES];
    logic        voice_rel [NUM_VOICES];
    logic [6:0]  voice_key [NUM_VOICES];
    logic [3:0]  voice_ch4 [NUM_VOICES];
    logic [47:0] voice_t0  [NUM_VOICES];
    logic [4:0]  listen_chan = '0;

    midi_req_t     pending_reqs[$];
    voice_result_t expected_results[$];
    int            outstanding = 0;
    int            errors = 0;
    int            cycles = 0;
    logic [47:0]   frame_now = '0;

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d requests outstanding", $time, outstanding);
            $display("Verification failed");
            $finish;
        end
    end

    // Active voice with this note and channel, lowest index first; -1 if none
    function automatic int find_voice(logic [6:0] note, logic [3:0] ch4);
        int hit;
        hit = -1;
        for (int i = NUM_VOICES - 1; i >= 0; i--)
            if (voice_on[i] && voice_key[i] == note && voice_ch4[i] == ch4)
                hit = i;
        return hit;
    endfunction

    // Apply one request to the local table and return the result it gives
    function automatic voice_result_t allocate_voice(midi_req_t r);
        voice_result_t res;
        logic [6:0]    vel;
        logic [3:0]    kind;
        logic [3:0]    ch4;
        logic [4:0]    chan;
        logic [2:0]    act;
        int            pick;
        res = '0;
        if (r.mode)
        begin
            if (voice_on[r.slot])
            begin
                voice_on[r.slot]  = 1'b0;
                voice_rel[r.slot] = 1'b0;
                res = '{r.slot, vsa_pkg::ACT_ENDED, {1'b0, voice_ch4[r.slot]} + 5'd1};
            end
            return res;
        end
        if (r.count < 2'd2)
            return res;
        vel  = (r.count == 2'd3) ? r.vel : 7'd0;
        kind = r.status[7:4];
        ch4  = r.status[3:0];
        chan = {1'b0, ch4} + 5'd1;
        if (listen_chan != 5'd0 && listen_chan != chan)
            return res;
        if (kind == vsa_pkg::KIND_NOTE_ON && vel != 7'd0)
        begin
            if (!r.playable)
                return res;
            // retrigger, else lowest free voice, else steal the oldest
            pick = find_voice(r.note, ch4);
            act  = vsa_pkg::ACT_RETRIG;
            if (pick < 0)
            begin
                for (int i = NUM_VOICES - 1; i >= 0; i--)
                    if (!voice_on[i])
                        pick = i;
                act = vsa_pkg::ACT_START;
            end
            if (pick < 0)
            begin
                pick = 0;
                for (int i = 1; i < NUM_VOICES; i++)
                    if (voice_t0[i] < voice_t0[pick])
                        pick = i;
                act = vsa_pkg::ACT_STEAL;
            end
            voice_on[pick]  = 1'b1;
            voice_rel[pick] = 1'b0;
            voice_key[pick] = r.note;
            voice_ch4[pick] = ch4;
            voice_t0[pick]  = r.frame;
            res = '{pick[3:0], act, chan};
        end
        else if (kind == vsa_pkg::KIND_NOTE_ON || kind == vsa_pkg::KIND_NOTE_OFF)
        begin
            pick = find_voice(r.note, ch4);
            if (pick >= 0)
            begin
                if (r.has_rel)
                begin
                    voice_rel[pick] = 1'b1;
                    res = '{pick[3:0], vsa_pkg::ACT_RELEASE, chan};
                end
                else
                begin
                    voice_on[pick]  = 1'b0;
                    voice_rel[pick] = 1'b0;
                    res = '{pick[3:0], vsa_pkg::ACT_STOP, chan};
                end
            end
        end
        return res;
    endfunction

    // Driver: bursts of requests with random gaps, now and then a full drain
    midi_req_t cur_req = '0;
    int        burst_left = 0;
    int        gap_left = 0;
    logic      drain_wait = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            drain_wait = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(allocate_voice(cur_req));
            if (!in_valid || !in_stall)
            begin
                if (drain_wait)
                begin
                    in_valid <= 1'b0;
                    if (expected_results.size() == 0)
                        drain_wait = 1'b0;
                end
                else if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid         <= 1'b1;
                    mode             <= cur_req.mode;
                    status_byte      <= cur_req.status;
                    note_number      <= cur_req.note;
                    velocity         <= cur_req.vel;
                    byte_count       <= cur_req.count;
                    zone_playable    <= cur_req.playable;
                    zone_has_release <= cur_req.has_rel;
                    frame_time       <= cur_req.frame;
                    voice_slot       <= cur_req.slot;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        drain_wait = ($urandom_range(0, 29) == 0);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: switches between free-running, random and heavy stalling
    int stall_style = 0;
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_style = 0;
            stall_left  = 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(20, 200);
            end
            else
            begin
                stall_left--;
            end
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 1) == 0);
                2:       out_stall <= ($urandom_range(0, 7) != 0);
                default: out_stall <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    voice_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result idx=%0d act=%0d chan=%0d",
                         $time, voice_index, action, voice_channel);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                outstanding--;
                if (voice_index !== want.idx)
                begin
                    $display("%0t: voice_index expected %0d actual %0d",
                             $time, want.idx, voice_index);
                    errors++;
                end
                if (action !== want.act)
                begin
                    $display("%0t: action expected %0d actual %0d",
                             $time, want.act, action);
                    errors++;
                end
                if (voice_channel !== want.chan)
                begin
                    $display("%0t: voice_channel expected %0d actual %0d",
                             $time, want.chan, voice_channel);
                    errors++;
                end
            end
        end
    end

    // Request builders
    function automatic midi_req_t midi_event(logic [3:0] kind, logic [3:0] ch4,
                                             logic [6:0] note, logic [6:0] vel,
                                             logic [1:0] count, logic playable,
                                             logic has_rel, logic [47:0] frame);
        midi_req_t r;
        r = '0;
        r.status   = {kind, ch4};
        r.note     = note;
        r.vel      = vel;
        r.count    = count;
        r.playable = playable;
        r.has_rel  = has_rel;
        r.frame    = frame;
        return r;
    endfunction

    function automatic midi_req_t voice_end(logic [3:0] slot);
        midi_req_t r;
        r = '0;
        r.mode = 1'b1;
        r.slot = slot;
        return r;
    endfunction

    task automatic send(midi_req_t r);
        pending_reqs.push_back(r);
        outstanding++;
    endtask

    // Wait for every result, then let the pipeline settle
    task automatic drain_all();
        while (outstanding != 0)
            @(posedge clk);
        repeat (NUM_VOICES + 8) @(posedge clk);
    endtask

    task automatic write_listen(logic [4:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        listen_chan = value;
    endtask

    // Mostly the listened channel or a few busy ones
    function automatic logic [3:0] pick_channel();
        if (listen_chan >= 5'd1 && listen_chan <= 5'd16 && $urandom_range(0, 4) != 0)
            return 4'(listen_chan - 5'd1);
        if ($urandom_range(0, 4) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, 2));
    endfunction

    // Frame clock: mostly rising, with ties and occasional jumps
    task automatic advance_frame();
        logic [63:0] wide;
        int          roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            wide      = {$urandom(), $urandom()};
            frame_now = wide[47:0];
        end
        else if (roll > 4)
        begin
            frame_now = frame_now + 48'($urandom_range(1, 1000));
        end
    endtask

    // Playing-style traffic: note-ons on a small key range, matching note-offs,
    // voice ends and some raw noise
    task automatic queue_performance(int n);
        midi_req_t   r;
        logic [63:0] wide;
        logic [3:0]  ch4;
        logic [6:0]  note;
        int          roll;
        for (int k = 0; k < n; k++)
        begin
            advance_frame();
            roll = $urandom_range(0, 99);
            ch4  = pick_channel();
            note = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'(60 + $urandom_range(0, 11));
            if (roll < 50)
            begin
                r = midi_event(vsa_pkg::KIND_NOTE_ON, ch4, note,
                               ($urandom_range(0, 15) == 0) ? 7'd0
                                                            : 7'($urandom_range(1, 127)),
                               ($urandom_range(0, 19) == 0) ? 2'd2 : 2'd3,
                               ($urandom_range(0, 9) != 0), 1'($urandom_range(0, 1)),
                               frame_now);
            end
            else if (roll < 75)
            begin
                r = midi_event(($urandom_range(0, 2) == 0) ? vsa_pkg::KIND_NOTE_ON
                                                           : vsa_pkg::KIND_NOTE_OFF,
                               ch4, note, 7'd0, 2'($urandom_range(2, 3)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               frame_now);
                if (r.status[7:4] == vsa_pkg::KIND_NOTE_OFF)
                    r.vel = 7'($urandom_range(0, 127));
            end
            else if (roll < 87)
            begin
                r = voice_end(4'($urandom_range(0, NUM_VOICES - 1)));
                r.frame = frame_now;
            end
            else
            begin
                wide = {$urandom(), $urandom()};
                r.mode     = 1'($urandom_range(0, 1));
                r.status   = 8'($urandom_range(0, 255));
                r.note     = 7'($urandom_range(0, 127));
                r.vel      = 7'($urandom_range(0, 127));
                r.count    = 2'($urandom_range(0, 3));
                r.playable = 1'($urandom_range(0, 1));
                r.has_rel  = 1'($urandom_range(0, 1));
                r.frame    = wide[47:0];
                r.slot     = 4'($urandom_range(0, 15));
            end
            send(r);
        end
    endtask

    // Stimulus
    initial
    begin
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            voice_on[i]  = 1'b0;
            voice_rel[i] = 1'b0;
            voice_key[i] = '0;
            voice_ch4[i] = '0;
            voice_t0[i]  = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: all channels accepted
        write_listen(5'd0);
        send(voice_end(4'd0));                              // end on empty table
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'd0, 7'd0, 7'd127, 2'd0,
                        1'b1, 1'b0, 48'd1));                // short
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'd0, 7'd0, 7'd127, 2'd1,
                        1'b1, 1'b0, 48'd1));                // short
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'd0, 7'd0, 7'd127, 2'd2,
                        1'b1, 1'b0, 48'd1));                // two-byte
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'd0, 7'd0, 7'd127, 2'd3,
                        1'b0, 1'b0, 48'd1));                // unplayable
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'd0, 7'd0, 7'd127, 2'd3,
                        1'b1, 1'b0, 48'd5));                // start
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'd0, 7'd0, 7'd1, 2'd3,
                        1'b1, 1'b0, 48'hFFFF_FFFF_FFFF));   // retrigger
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'hF, 7'd127, 7'd1, 2'd3,
                        1'b1, 1'b1, 48'd9));                // channel 16
        send(midi_event(KIND_POLY_PRESSURE, 4'd0, 7'd0, 7'd64, 2'd3,
                        1'b1, 1'b1, 48'd9));
        send(midi_event(vsa_pkg::KIND_NOTE_OFF, 4'd0, 7'd0, 7'd64, 2'd3,
                        1'b1, 1'b1, 48'd9));                // release
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'hF, 7'd127, 7'd0, 2'd3,
                        1'b1, 1'b0, 48'd9));                // zero-vel stop
        send(midi_event(vsa_pkg::KIND_NOTE_OFF, 4'd3, 7'd50, 7'd0, 2'd3,
                        1'b1, 1'b0, 48'd9));                // unmatched
        // Fill the table with tied start times, then steal
        for (int i = 1; i < NUM_VOICES; i++)
            send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'd2, 7'(20 + i), 7'd100, 2'd3,
                            1'b1, 1'b0, 48'd0));
        send(midi_event(vsa_pkg::KIND_NOTE_ON, 4'd5, 7'd90, 7'd100, 2'd3,
                        1'b1, 1'b0, 48'd7));                // steal
        send(voice_end(4'd15));                             // end active
        drain_all();

        // Random phases across listen settings; the first one drains midway
        frame_now = 48'd100;
        queue_performance(100);
        drain_all();
        queue_performance(100);
        drain_all();

        write_listen(5'd16);
        queue_performance(100);
        drain_all();
        write_listen(5'd1);
        queue_performance(100);
        drain_all();
        write_listen(5'd31);
        queue_performance(30);
        drain_all();
        write_listen(5'd17);
        queue_performance(20);
        drain_all();
        write_listen(5'($urandom_range(2, 15)));
        queue_performance(100);
        drain_all();
        write_listen(5'd0);
        queue_performance(60);
        drain_all();

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vsa_pkg.sv
rtl/vsa_ram.sv
rtl/vsa_decode.sv
rtl/synth_voice_allocator_top.sv
rtl/vsa_checker.sv
dv/tb_synth_voice_allocator_top.sv
